// ----- design/prqs_pkg.sv -----
// ----------------------------------------------------------------------------
// prqs_pkg
// shared types and constants for the per-cpu run queue scheduler
// ----------------------------------------------------------------------------
package prqs_pkg;

    typedef enum logic [2:0] {
        CMD_RUNNABLE = 3'd0,
        CMD_BLOCK    = 3'd1,
        CMD_ZOMBIE   = 3'd2,
        CMD_FREE     = 3'd3,
        CMD_RUNNING  = 3'd4,
        CMD_BOOT     = 3'd5,
        CMD_YIELD    = 3'd6,
        CMD_TICK     = 3'd7
    } t_cmd;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_RUNNABLE = 3'd1;
    localparam logic [2:0] ST_RUNNING  = 3'd2;
    localparam logic [2:0] ST_BLOCKED  = 3'd3;
    localparam logic [2:0] ST_ZOMBIE   = 3'd4;

    localparam int CNT_W = 48;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] task_id;
        logic [2:0] cpu_id;
    } t_in_word;

    typedef struct packed {
        logic             status;
        logic [5:0]       current_task;
        logic             current_idle;
        logic             switched;
        logic             resched_pending;
        logic [CNT_W-1:0] total_ticks;
        logic [CNT_W-1:0] idle_ticks;
    } t_out_word;

endpackage

// ----- design/per_cpu_run_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// per_cpu_run_queue_scheduler
// round-robin fifo run queues per cpu over a shared task table
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_valid / o_stall) takes one command word: make runnable,
//   block, zombie, free, mark running, boot current, yield or tick.
//   output channel (o_valid / i_stall) returns one result word per command.
// sequencing:
//   a command runs on a sequencer over the task table, a synchronous memory
//   with a registered read port; yield drops stale queue entries as it pops
//   them, until it finds a runnable task or the queue is empty; make runnable
//   unlinks a queued task and pushes it at the tail of the queue.
//   one command is in flight at a time; the next is accepted once the
//   sequencer is idle again.
// reset:
//   synchronous, active low. task records reset through a valid bit per
//   entry; invalid entries read as unused, no home, not queued.
// stall:
//   the result sits in an output register; a stalled result only holds the
//   next command in its final step until the register is taken.
// ----------------------------------------------------------------------------
module per_cpu_run_queue_scheduler
    import prqs_pkg::*;
#(
    parameter int MAX_TASKS = 64,
    parameter int NUM_CPUS  = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int LW = TW + 1;
    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam logic [LW-1:0] NONE = LW'(MAX_TASKS);
    localparam logic [3:0] HOME_NONE = 4'd15;

    // task record: status, home, queued, resched, next, prev
    typedef struct packed {
        logic [2:0]    st;
        logic [3:0]    home;
        logic          queued;
        logic          resched;
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
    } t_rec;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_T, S_CHK_T, S_UL_P, S_UL_PW, S_UL_N, S_UL_NW, S_AFTER_UL,
        S_PUSH_TL, S_PUSH_TLW, S_PUSH_T, S_PUSH_TW,
        S_Y_RD_CUR, S_Y_CUR, S_POP_RD, S_POP_H, S_POP_N, S_POP_NW,
        S_TK_RD, S_TK, S_FIN_RD, S_FIN, S_OUT
    } t_state;

    t_rec              mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_vld;
    logic              r_we;
    logic [TW-1:0]     r_waddr, r_raddr;
    t_rec              r_wdata, r_rdq;
    logic              r_rdv;
    logic              r_rd_en;
    t_rec              rd;

    t_state            r_state;
    logic [2:0]        r_cmd;
    logic [TW-1:0]     r_t;
    logic [CW-1:0]     r_c;
    t_rec              r_trec;
    logic [LW-1:0]     r_head [NUM_CPUS];
    logic [LW-1:0]     r_tail [NUM_CPUS];
    logic [LW-1:0]     r_cur  [NUM_CPUS];
    logic [CW-1:0]     r_uc;
    logic [LW-1:0]     r_prev_cur;
    logic              r_status;
    logic              r_sw;
    logic [LW-1:0]     r_ptl;
    logic [CNT_W-1:0]  r_tot, r_idl;
    logic              r_ov;
    t_out_word         r_od;
    logic              out_load;

    // task memory, write port and registered read port
    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem[r_waddr] <= r_wdata;
        end
        if (r_rd_en) begin
            r_rdq <= mem[r_raddr];
        end
    end

    always_comb begin
        rd = r_rdq;
        if (!r_rdv) begin
            rd.st      = ST_UNUSED;
            rd.home    = HOME_NONE;
            rd.queued  = 1'b0;
            rd.resched = 1'b0;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_od;

    // result word moves into the output register once it is free or taken
    assign out_load = (r_state == S_OUT) && (!r_ov || !i_stall);

    function automatic logic [CW-1:0] fold_cpu(input logic [3:0] h);
        return (32'(h) < NUM_CPUS) ? CW'(h) : '0;
    endfunction

    // sequencer
    always_ff @(posedge i_clk) begin
        r_we    <= 1'b0;
        r_rd_en <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_ov    <= 1'b0;
            r_tot   <= '0;
            r_idl   <= '0;
            for (int i = 0; i < NUM_CPUS; i++) begin
                r_head[i] <= NONE;
                r_tail[i] <= NONE;
                r_cur[i]  <= NONE;
            end
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if (r_we) begin
                r_vld[r_waddr] <= 1'b1;
            end
            // hold while a memory read lands in r_rdq
            if (!r_rd_en) begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_valid) begin
                            r_cmd    <= i_data.cmd;
                            r_t      <= TW'(i_data.task_id);
                            r_c      <= (32'(i_data.cpu_id) < NUM_CPUS) ?
                                        CW'(i_data.cpu_id) : '0;
                            r_status <= 1'b0;
                            r_sw     <= 1'b0;
                            if (i_data.cmd == CMD_YIELD) begin
                                r_state <= S_Y_RD_CUR;
                            end else if (i_data.cmd == CMD_TICK) begin
                                r_state <= S_TK_RD;
                            end else if (32'(i_data.task_id) < MAX_TASKS) begin
                                r_state <= S_RD_T;
                            end else begin
                                r_state <= S_FIN_RD;
                            end
                        end
                    end
                    S_RD_T: begin
                        r_raddr <= r_t;
                        r_rdv   <= r_vld[r_t];
                        r_rd_en <= 1'b1;
                        r_state <= S_CHK_T;
                    end
                    S_CHK_T: begin
                        r_trec <= rd;
                        r_uc   <= fold_cpu(rd.home);
                        if (rd.queued) begin
                            r_state <= S_UL_P;
                        end else begin
                            r_state <= S_AFTER_UL;
                        end
                    end
                    // unlink: fix prev's next or head, then next's prev or tail
                    S_UL_P: begin
                        if (r_trec.prv != NONE) begin
                            r_raddr <= TW'(r_trec.prv);
                            r_rdv   <= r_vld[TW'(r_trec.prv)];
                            r_rd_en <= 1'b1;
                            r_state <= S_UL_PW;
                        end else begin
                            r_head[r_uc] <= r_trec.nxt;
                            r_state      <= S_UL_N;
                        end
                    end
                    S_UL_PW: begin
                        r_wdata     <= r_rdq;
                        r_wdata.nxt <= r_trec.nxt;
                        r_waddr     <= TW'(r_trec.prv);
                        r_we        <= 1'b1;
                        r_state     <= S_UL_N;
                    end
                    S_UL_N: begin
                        if (r_we) begin
                            // wait for write to land before reading
                        end else if (r_trec.nxt != NONE) begin
                            r_raddr <= TW'(r_trec.nxt);
                            r_rdv   <= r_vld[TW'(r_trec.nxt)];
                            r_rd_en <= 1'b1;
                            r_state <= S_UL_NW;
                        end else begin
                            r_tail[r_uc] <= r_trec.prv;
                            r_state      <= S_AFTER_UL;
                        end
                    end
                    S_UL_NW: begin
                        r_wdata     <= r_rdq;
                        r_wdata.prv <= r_trec.prv;
                        r_waddr     <= TW'(r_trec.nxt);
                        r_we        <= 1'b1;
                        r_state     <= S_AFTER_UL;
                    end
                    // apply the command to the task record
                    S_AFTER_UL: begin
                        r_trec.queued <= 1'b0;
                        r_trec.nxt    <= NONE;
                        r_trec.prv    <= NONE;
                        priority case (r_cmd)
                            CMD_RUNNABLE: begin
                                r_trec.st <= ST_RUNNABLE;
                                r_state   <= S_PUSH_TL;
                            end
                            CMD_BOOT: begin
                                r_trec.st   <= ST_RUNNING;
                                r_trec.home <= 4'(r_c);
                                r_cur[r_c]  <= LW'(r_t);
                                r_state     <= S_PUSH_TW;
                            end
                            default: begin
                                r_trec.st <= (r_cmd == CMD_BLOCK)  ? ST_BLOCKED :
                                             (r_cmd == CMD_ZOMBIE) ? ST_ZOMBIE  :
                                             (r_cmd == CMD_FREE)   ? ST_UNUSED  : ST_RUNNING;
                                r_trec.home <= (r_cmd == CMD_FREE) ? HOME_NONE :
                                    (32'(r_trec.home) < NUM_CPUS) ? r_trec.home : 4'(r_c);
                                r_state <= S_PUSH_TW;
                            end
                        endcase
                    end
                    // push r_t at tail of r_c
                    S_PUSH_TL: begin
                        if (r_we) begin
                        end else if (r_tail[r_c] != NONE) begin
                            r_ptl   <= r_tail[r_c];
                            r_raddr <= TW'(r_tail[r_c]);
                            r_rdv   <= r_vld[TW'(r_tail[r_c])];
                            r_rd_en <= 1'b1;
                            r_state <= S_PUSH_TLW;
                        end else begin
                            r_ptl        <= NONE;
                            r_head[r_c]  <= LW'(r_t);
                            r_state      <= S_PUSH_T;
                        end
                    end
                    S_PUSH_TLW: begin
                        r_wdata     <= r_rdq;
                        r_wdata.nxt <= LW'(r_t);
                        r_waddr     <= TW'(r_ptl);
                        r_we        <= 1'b1;
                        r_state     <= S_PUSH_T;
                    end
                    S_PUSH_T: begin
                        r_trec.prv    <= r_ptl;
                        r_trec.nxt    <= NONE;
                        r_trec.queued <= 1'b1;
                        r_trec.home   <= 4'(r_c);
                        r_tail[r_c]   <= LW'(r_t);
                        r_state       <= S_PUSH_TW;
                    end
                    S_PUSH_TW: begin
                        r_wdata <= r_trec;
                        r_waddr <= r_t;
                        r_we    <= 1'b1;
                        r_state <= (r_cmd == CMD_YIELD) ? S_POP_RD : S_FIN_RD;
                    end
                    // yield: requeue a running current task
                    S_Y_RD_CUR: begin
                        r_prev_cur <= r_cur[r_c];
                        if (r_cur[r_c] != NONE) begin
                            r_t     <= TW'(r_cur[r_c]);
                            r_raddr <= TW'(r_cur[r_c]);
                            r_rdv   <= r_vld[TW'(r_cur[r_c])];
                            r_rd_en <= 1'b1;
                            r_state <= S_Y_CUR;
                        end else begin
                            r_state <= S_POP_RD;
                        end
                    end
                    S_Y_CUR: begin
                        r_trec <= rd;
                        if (rd.st == ST_RUNNING) begin
                            r_trec.st <= ST_RUNNABLE;
                            if (rd.queued) begin
                                r_status <= 1'b1;
                                r_state  <= S_PUSH_TW;
                            end else begin
                                r_state <= S_PUSH_TL;
                            end
                        end else begin
                            r_state <= S_POP_RD;
                        end
                    end
                    // pop head until runnable or empty
                    S_POP_RD: begin
                        if (r_we) begin
                        end else if (r_head[r_c] == NONE) begin
                            r_cur[r_c] <= NONE;
                            r_sw       <= (r_prev_cur != NONE);
                            r_state    <= S_FIN_RD;
                        end else begin
                            r_t     <= TW'(r_head[r_c]);
                            r_raddr <= TW'(r_head[r_c]);
                            r_rdv   <= r_vld[TW'(r_head[r_c])];
                            r_rd_en <= 1'b1;
                            r_state <= S_POP_H;
                        end
                    end
                    S_POP_H: begin
                        r_trec        <= rd;
                        r_trec.queued <= 1'b0;
                        r_trec.nxt    <= NONE;
                        r_trec.prv    <= NONE;
                        r_head[r_c]   <= rd.nxt;
                        if (rd.nxt == NONE) begin
                            r_tail[r_c] <= NONE;
                        end
                        if (rd.st == ST_RUNNABLE) begin
                            r_trec.st      <= ST_RUNNING;
                            r_trec.home    <= 4'(r_c);
                            r_trec.resched <= 1'b0;
                            r_cur[r_c]     <= LW'(r_t);
                            r_sw           <= (LW'(r_t) != r_prev_cur);
                        end
                        r_state <= S_POP_N;
                    end
                    S_POP_N: begin
                        if (r_head[r_c] != NONE) begin
                            r_raddr <= TW'(r_head[r_c]);
                            r_rdv   <= r_vld[TW'(r_head[r_c])];
                            r_rd_en <= 1'b1;
                        end
                        r_wdata <= r_trec;
                        r_waddr <= r_t;
                        r_we    <= 1'b1;
                        r_state <= S_POP_NW;
                    end
                    S_POP_NW: begin
                        if (r_head[r_c] != NONE) begin
                            r_wdata     <= r_rdq;
                            r_wdata.prv <= NONE;
                            r_waddr     <= TW'(r_head[r_c]);
                            r_we        <= 1'b1;
                        end
                        r_state <= (r_cur[r_c] == LW'(r_t) && r_trec.st == ST_RUNNING)
                                   ? S_FIN_RD : S_POP_RD;
                    end
                    // tick
                    S_TK_RD: begin
                        r_tot <= r_tot + 1'b1;
                        if (r_cur[r_c] == NONE) begin
                            r_idl   <= r_idl + 1'b1;
                            r_state <= S_FIN_RD;
                        end else begin
                            r_t     <= TW'(r_cur[r_c]);
                            r_raddr <= TW'(r_cur[r_c]);
                            r_rdv   <= r_vld[TW'(r_cur[r_c])];
                            r_rd_en <= 1'b1;
                            r_state <= S_TK;
                        end
                    end
                    S_TK: begin
                        if (rd.st == ST_RUNNING) begin
                            r_wdata         <= rd;
                            r_wdata.resched <= 1'b1;
                            r_waddr         <= r_t;
                            r_we            <= 1'b1;
                        end
                        r_state <= S_FIN_RD;
                    end
                    // read current task record for the result
                    S_FIN_RD: begin
                        if (r_we) begin
                        end else begin
                            r_raddr <= TW'(r_cur[r_c]);
                            r_rdv   <= r_vld[TW'(r_cur[r_c])];
                            r_rd_en <= 1'b1;
                            r_state <= S_FIN;
                        end
                    end
                    S_FIN: begin
                        r_state <= S_OUT;
                    end
                    // wait here until the output register can take the word
                    S_OUT: begin
                        if (out_load) begin
                            r_od.status          <= r_status;
                            r_od.current_task    <= (r_cur[r_c] != NONE) ?
                                                    6'(r_cur[r_c]) : 6'd0;
                            r_od.current_idle    <= (r_cur[r_c] == NONE);
                            r_od.switched        <= r_sw;
                            r_od.resched_pending <= (r_cur[r_c] != NONE) && rd.resched;
                            r_od.total_ticks     <= r_tot;
                            r_od.idle_ticks      <= r_idl;
                            r_state              <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run queue scheduler testbench
// drives command words into the per-cpu scheduler, predicts each result word
// with a behavioral model of the queues and counters, and checks every field
// ----------------------------------------------------------------------------
module testbench
    import prqs_pkg::*;
();

    localparam int NTASK = 64;
    localparam int NCPU = 4;
    localparam logic [6:0] LNONE = 7'd64;
    localparam logic [3:0] HNONE = 4'd15;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in_word i_data;
    logic o_valid;
    logic i_stall;
    t_out_word o_data;

    per_cpu_run_queue_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    // predictor state
    logic [2:0] m_status [NTASK];
    logic [3:0] m_home [NTASK];
    logic m_queued [NTASK];
    logic m_resched [NTASK];
    logic [6:0] m_next [NTASK];
    logic [6:0] m_prev [NTASK];
    logic [6:0] m_head [NCPU];
    logic [6:0] m_tail [NCPU];
    logic [6:0] m_cur [NCPU];
    logic [47:0] m_total;
    logic [47:0] m_idle;

    t_out_word expected_words[$];
    int mismatches;
    int words_checked;
    bit rx_quiet;
    bit tx_quiet;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // timeout
    initial begin
        #200ms;
        $display("testbench: errors");
        $finish;
    end

    function automatic void sched_reset();
        for (int i = 0; i < NTASK; i++) begin
            m_status[i] = ST_UNUSED;
            m_home[i] = HNONE;
            m_queued[i] = 1'b0;
            m_resched[i] = 1'b0;
            m_next[i] = LNONE;
            m_prev[i] = LNONE;
        end
        for (int c = 0; c < NCPU; c++) begin
            m_head[c] = LNONE;
            m_tail[c] = LNONE;
            m_cur[c] = LNONE;
        end
        m_total = '0;
        m_idle = '0;
    endfunction

    function automatic void queue_unlink(int c, int t);
        logic [6:0] p;
        logic [6:0] n;
        p = m_prev[t];
        n = m_next[t];
        if (p < LNONE) m_next[p] = n;
        else m_head[c] = n;
        if (n < LNONE) m_prev[n] = p;
        else m_tail[c] = p;
        m_prev[t] = LNONE;
        m_next[t] = LNONE;
        m_queued[t] = 1'b0;
    endfunction

    function automatic logic queue_push(int c, int t);
        logic [6:0] tl;
        tl = m_tail[c];
        if (m_queued[t]) return 1'b1;
        m_prev[t] = tl;
        m_next[t] = LNONE;
        if (tl < LNONE) m_next[tl] = 7'(t);
        else m_head[c] = 7'(t);
        m_tail[c] = 7'(t);
        m_queued[t] = 1'b1;
        m_home[t] = 4'(c);
        return 1'b0;
    endfunction

    function automatic logic [6:0] queue_pop(int c);
        logic [6:0] t;
        logic [6:0] n;
        t = m_head[c];
        if (t >= LNONE) return LNONE;
        n = m_next[t];
        m_head[c] = n;
        if (n < LNONE) m_prev[n] = LNONE;
        else m_tail[c] = LNONE;
        m_prev[t] = LNONE;
        m_next[t] = LNONE;
        m_queued[t] = 1'b0;
        return t;
    endfunction

    function automatic void dequeue_task(int t);
        int c;
        c = m_home[t];
        if (!m_queued[t]) return;
        if (c >= NCPU) c = 0;
        queue_unlink(c, t);
    endfunction

    function automatic void change_status(int t, int loc, logic [2:0] st);
        int c;
        c = m_home[t];
        if (c >= NCPU) c = loc;
        dequeue_task(t);
        m_home[t] = (st == ST_UNUSED) ? HNONE : 4'(c);
        m_status[t] = st;
    endfunction

    function automatic t_out_word schedule_step(t_in_word w);
        t_out_word r;
        int t;
        int c;
        logic st;
        logic sw;
        logic [6:0] prev;
        logic [6:0] nxt;
        logic [6:0] p;
        logic [6:0] k;
        t = w.task_id;
        c = w.cpu_id;
        st = 1'b0;
        sw = 1'b0;
        if (c >= NCPU) c = 0;
        case (t_cmd'(w.cmd))
            CMD_RUNNABLE: begin
                dequeue_task(t);
                m_status[t] = ST_RUNNABLE;
                st = queue_push(c, t);
            end
            CMD_BLOCK: change_status(t, c, ST_BLOCKED);
            CMD_ZOMBIE: change_status(t, c, ST_ZOMBIE);
            CMD_FREE: change_status(t, c, ST_UNUSED);
            CMD_RUNNING: change_status(t, c, ST_RUNNING);
            CMD_BOOT: begin
                dequeue_task(t);
                m_home[t] = 4'(c);
                m_status[t] = ST_RUNNING;
                m_cur[c] = 7'(t);
            end
            CMD_YIELD: begin
                prev = m_cur[c];
                if (prev < LNONE && m_status[prev] == ST_RUNNING) begin
                    m_status[prev] = ST_RUNNABLE;
                    st = queue_push(c, prev);
                end
                nxt = LNONE;
                for (int g = 0; g <= NTASK; g++) begin
                    p = queue_pop(c);
                    if (p >= LNONE) break;
                    if (m_status[p] == ST_RUNNABLE) begin
                        nxt = p;
                        break;
                    end
                end
                if (nxt < LNONE) begin
                    m_home[nxt] = 4'(c);
                    m_status[nxt] = ST_RUNNING;
                    m_resched[nxt] = 1'b0;
                end
                m_cur[c] = nxt;
                sw = (nxt != prev);
            end
            default: begin
                k = m_cur[c];
                m_total = m_total + 48'd1;
                if (k >= LNONE) m_idle = m_idle + 48'd1;
                else if (m_status[k] == ST_RUNNING) m_resched[k] = 1'b1;
            end
        endcase
        k = m_cur[c];
        r.status = st;
        r.current_task = (k < LNONE) ? k[5:0] : 6'd0;
        r.current_idle = (k >= LNONE);
        r.switched = sw;
        r.resched_pending = (k < LNONE) ? m_resched[k] : 1'b0;
        r.total_ticks = m_total;
        r.idle_ticks = m_idle;
        return r;
    endfunction

    // send one command word, with random gaps before it
    task automatic send_word(t_cmd cmd, int tid, int cpu);
        t_in_word w;
        if (!tx_quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        w.cmd = cmd;
        w.task_id = 6'(tid);
        w.cpu_id = 3'(cpu);
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_words.push_back(schedule_step(w));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall bursts
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!rx_quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", o_data);
            end else begin
                e = expected_words.pop_front();
                words_checked++;
                if (o_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp st=%0d cur=%0d idle=%0d sw=%0d rs=%0d %0d %0d",
                            e.status, e.current_task, e.current_idle, e.switched,
                            e.resched_pending, e.total_ticks, e.idle_ticks);
                        $display("          got st=%0d cur=%0d idle=%0d sw=%0d rs=%0d %0d %0d",
                            o_data.status, o_data.current_task, o_data.current_idle,
                            o_data.switched, o_data.resched_pending, o_data.total_ticks,
                            o_data.idle_ticks);
                    end
                end
            end
        end
    end

    // every command and field extreme, and a stale current
    task automatic test_directed();
        send_word(CMD_TICK, 0, 0);
        send_word(CMD_YIELD, 0, 7);
        send_word(CMD_RUNNABLE, 0, 0);
        send_word(CMD_RUNNABLE, 63, 0);
        send_word(CMD_RUNNABLE, 63, 0);
        send_word(CMD_RUNNABLE, 5, 3);
        send_word(CMD_RUNNABLE, 5, 5);
        send_word(CMD_BOOT, 63, 2);
        send_word(CMD_TICK, 63, 2);
        send_word(CMD_YIELD, 0, 2);
        send_word(CMD_BOOT, 9, 1);
        send_word(CMD_BLOCK, 9, 1);
        send_word(CMD_YIELD, 0, 1);
        send_word(CMD_RUNNABLE, 10, 0);
        send_word(CMD_ZOMBIE, 10, 4);
        send_word(CMD_YIELD, 0, 0);
        send_word(CMD_FREE, 0, 0);
        send_word(CMD_RUNNING, 42, 6);
        send_word(CMD_RUNNABLE, 21, 3);
        send_word(CMD_RUNNING, 21, 0);
        send_word(CMD_YIELD, 0, 3);
        send_word(CMD_TICK, 0, 3);
        send_word(CMD_TICK, 0, 7);
    endtask

    // random scheduling traffic over a small task pool mostly
    task automatic test_random(int n);
        int r;
        int tid;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            tid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
            if (r < 30) send_word(CMD_RUNNABLE, tid, $urandom_range(0, 7));
            else if (r < 50) send_word(CMD_YIELD, tid, $urandom_range(0, 7));
            else if (r < 65) send_word(CMD_TICK, tid, $urandom_range(0, 7));
            else send_word(t_cmd'($urandom_range(1, 5)), tid, $urandom_range(0, 7));
            if (i == n / 2) drain();
        end
    endtask

    initial begin
        mismatches = 0;
        words_checked = 0;
        rx_quiet = 0;
        tx_quiet = 0;
        i_valid = 1'b0;
        i_data = '0;
        i_rst_n = 1'b0;
        sched_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1500);
        rx_quiet = 1;
        tx_quiet = 1;
        test_random(400);
        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d command words: queueing, yields, ticks and state changes",
            words_checked);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("mismatch count %0d", mismatches);
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

// ----- per_cpu_run_queue_scheduler.f -----
design/prqs_pkg.sv
design/per_cpu_run_queue_scheduler.sv
dv/testbench.sv
